[rtl/smpq_pkg.sv]
`default_nettype none

package smpq_pkg;

    // Queue geometry
    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Command codes on the cmd port
    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_READOUT = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_READOUT  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // Operation applied to the key cells
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } dp_op_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t  op;
        logic    emit;
        status_t st;
        logic    last;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             full;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/sorted_min_priority_queue.sv]
`default_nettype none

// Channel   Handshake           Ports
// -------   -----------------   ------------------------------------------
// command   start & !busy       cmd, new_key
// result    done (one cycle)    out_key, status, occupancy, last
//
// Insert, delete, and any empty or full report show their result with done in
// the cycle after the command is taken. A readout of N keys shows one key per
// cycle; busy stays high after the transfer while the remaining keys rotate
// past cell 0. Reset clears the fill count, done and the controller state;
// key cells and result registers are never cleared.
// The receiver cannot stall: each result is on the ports for one cycle.
module sorted_min_priority_queue (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        cmd,
    input  wire logic signed [smpq_pkg::KEY_W-1:0] new_key,
    output logic                                   done,
    output logic signed [smpq_pkg::KEY_W-1:0]      out_key,
    output logic [2:0]                             status,
    output logic [smpq_pkg::CNT_W-1:0]             occupancy,
    output logic                                   last
);
    import smpq_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    smpq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd)
    );

    smpq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat),
        .new_key   (new_key),
        .out_key   (out_key),
        .status    (status),
        .occupancy (occupancy),
        .last      (last),
        .done      (done)
    );

endmodule

`default_nettype wire

[rtl/smpq_datapath.sv]
`default_nettype none

module smpq_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire smpq_pkg::dp_cmd_t             dp_cmd,
    output smpq_pkg::dp_stat_t                 dp_stat,
    input  wire logic signed [smpq_pkg::KEY_W-1:0] new_key,
    output logic signed [smpq_pkg::KEY_W-1:0]  out_key,
    output logic [2:0]                         status,
    output logic [smpq_pkg::CNT_W-1:0]         occupancy,
    output logic                               last,
    output logic                               done
);
    import smpq_pkg::*;

    logic signed [KEY_W-1:0] key_reg  [CAPACITY];
    logic signed [KEY_W-1:0] key_next [CAPACITY];
    logic [CAPACITY-1:0]     le;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    logic signed [KEY_W-1:0] out_key_reg;
    logic signed [KEY_W-1:0] out_key_next;
    logic [2:0]              status_reg;
    logic [CNT_W-1:0]        occupancy_reg;
    logic                    last_reg;
    logic                    done_reg;

    // Per-cell compare and shift
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_W-1:0] up_key;
        logic signed [KEY_W-1:0] ins_key;

        // held key that stays ahead of the new key (equal keys stay ahead)
        assign le[g] = (CNT_W'(g) < count_reg) && (key_reg[g] <= new_key);

        if (g == CAPACITY - 1) begin : g_tail
            assign up_key = key_reg[g];
        end
        else begin : g_body
            assign up_key = key_reg[g + 1];
        end

        if (g == 0) begin : g_head
            assign ins_key = le[g] ? key_reg[g] : new_key;
        end
        else begin : g_rest
            assign ins_key = le[g] ? key_reg[g] : (le[g - 1] ? new_key : key_reg[g - 1]);
        end

        always_comb
        begin
            case (dp_cmd.op)
                OP_INSERT: key_next[g] = ins_key;
                OP_DELETE: key_next[g] = up_key;
                // rotate the held keys left by one, head wraps to the tail
                OP_ROTATE: key_next[g] = (CNT_W'(g + 1) == count_reg) ? key_reg[0] : up_key;
                default:   key_next[g] = key_reg[g];
            endcase
        end

        always_ff @(posedge clk)
        begin
            key_reg[g] <= key_next[g];
        end
    end

    // Fill count
    always_comb
    begin
        case (dp_cmd.op)
            OP_INSERT: count_next = count_reg + CNT_W'(1);
            OP_DELETE: count_next = count_reg - CNT_W'(1);
            default:   count_next = count_reg;
        endcase
    end

    // Result key select
    always_comb
    begin
        case (dp_cmd.st)
            ST_INSERTED, ST_FULL:   out_key_next = new_key;
            ST_REMOVED, ST_READOUT: out_key_next = key_reg[0];
            default:                out_key_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= dp_cmd.emit;
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.emit)
        begin
            out_key_reg   <= out_key_next;
            status_reg    <= dp_cmd.st;
            occupancy_reg <= count_next;
            last_reg      <= dp_cmd.last;
        end
    end

    assign dp_stat.count = count_reg;
    assign dp_stat.empty = (count_reg == '0);
    assign dp_stat.full  = (count_reg == CNT_W'(CAPACITY));

    assign out_key   = out_key_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;
    assign last      = last_reg;
    assign done      = done_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.op == OP_INSERT) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the fill count");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.op == OP_INSERT) |-> !dp_stat.full)
        else $error("insert issued on a full queue");

endmodule

`default_nettype wire

[rtl/smpq_ctrl.sv]
`default_nettype none

module smpq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         cmd,
    output logic                    busy,
    input  wire smpq_pkg::dp_stat_t dp_stat,
    output smpq_pkg::dp_cmd_t       dp_cmd
);
    import smpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] remain_reg;
    logic [CNT_W-1:0] remain_next;

    // Command decode and readout sequencing
    always_comb
    begin
        dp_cmd.op   = OP_HOLD;
        dp_cmd.emit = 1'b0;
        dp_cmd.st   = ST_EMPTY;
        dp_cmd.last = 1'b0;
        state_next  = state_reg;
        remain_next = remain_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_INSERT:
                        begin
                            dp_cmd.emit = 1'b1;
                            dp_cmd.last = 1'b1;
                            if (dp_stat.full)
                            begin
                                dp_cmd.st = ST_FULL;
                            end
                            else
                            begin
                                dp_cmd.op = OP_INSERT;
                                dp_cmd.st = ST_INSERTED;
                            end
                        end
                        CMD_DELETE:
                        begin
                            dp_cmd.emit = 1'b1;
                            dp_cmd.last = 1'b1;
                            if (!dp_stat.empty)
                            begin
                                dp_cmd.op = OP_DELETE;
                                dp_cmd.st = ST_REMOVED;
                            end
                        end
                        CMD_READOUT:
                        begin
                            dp_cmd.emit = 1'b1;
                            if (dp_stat.empty)
                            begin
                                dp_cmd.last = 1'b1;
                            end
                            else
                            begin
                                dp_cmd.op   = OP_ROTATE;
                                dp_cmd.st   = ST_READOUT;
                                dp_cmd.last = (dp_stat.count == CNT_W'(1));
                                remain_next = dp_stat.count - CNT_W'(1);
                                if (dp_stat.count != CNT_W'(1))
                                begin
                                    state_next = S_READ;
                                end
                            end
                        end
                        default:
                        begin
                            // unused code: no change, no result
                        end
                    endcase
                end
            end
            S_READ:
            begin
                dp_cmd.op   = OP_ROTATE;
                dp_cmd.emit = 1'b1;
                dp_cmd.st   = ST_READOUT;
                dp_cmd.last = (remain_reg == CNT_W'(1));
                remain_next = remain_reg - CNT_W'(1);
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

    assign busy = (state_reg == S_READ);

    // Checks
    a_read_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (remain_reg != '0))
        else $error("readout running with nothing left");

    a_last_ends_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && dp_cmd.last) |=> (state_reg == S_IDLE))
        else $error("readout continued after its last key");

    a_read_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (remain_reg < dp_stat.count))
        else $error("readout longer than the fill count");

endmodule

`default_nettype wire
